// File: rtl/tphc_pkg.sv
// shared constants and helper functions of the compensation pipeline
package tphc_pkg;

   localparam int HUM_FRAC_BITS_DEF = 10;

   // configuration register indexes
   localparam logic [2:0] CSR_TEMP       = 3'd0;
   localparam logic [2:0] CSR_PRESS_LO   = 3'd1;
   localparam logic [2:0] CSR_PRESS_HI   = 3'd2;
   localparam logic [2:0] CSR_PRESS_NINE = 3'd3;
   localparam logic [2:0] CSR_HUM        = 3'd4;

   // q24 fixed point
   localparam logic signed [63:0] Q_ONE = 64'sd16777216;
   localparam logic signed [63:0] Q_LIM = 64'sd4611686018427387903;
   localparam logic signed [63:0] Q_HUNDRED = 64'sd1677721600;

   localparam int DIV_W = 32;

   function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
      logic signed [31:0] s;
      s = $signed(x);
      return 32'(s >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function automatic logic signed [63:0] qsat(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > Q_LIM) r = Q_LIM;
      if (v < -Q_LIM) r = -Q_LIM;
      return r;
   endfunction

   // divide by four, truncating toward zero
   function automatic logic signed [63:0] div4_tz(input logic signed [63:0] p);
      logic signed [63:0] adj;
      adj = p + (p[63] ? 64'sd3 : 64'sd0);
      return adj >>> 2;
   endfunction

endpackage

// File: rtl/tphc_delay.sv
// fixed-length delay line for payload alignment
module tphc_delay #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
         tap_ff[k] <= tap_ff[k-1];
      end
   end

   assign q = tap_ff[DEPTH-1];
endmodule

// File: rtl/tphc_qmul.sv
// saturating q24 multiply, three stages
module tphc_qmul
   import tphc_pkg::*;
(
   input  logic               clock,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic signed [63:0] r
);
   logic [63:0] ua, ub;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic        neg1_ff, neg2_ff;
   logic [63:0] mid, lo_in, hi_in, lo_ff, hi_ff;
   logic [63:0] mag;
   logic signed [63:0] r_ff, r_in;

   always_comb begin
      ua = a[63] ? (64'd0 - a) : a;
      ub = b[63] ? (64'd0 - b) : b;
   end

   // partial products of the magnitudes
   always_ff @(posedge clock) begin
      neg1_ff <= a[63] ^ b[63];
      p00_ff  <= ua[31:0] * ub[31:0];
      p01_ff  <= ua[31:0] * ub[63:32];
      p10_ff  <= ua[63:32] * ub[31:0];
      p11_ff  <= ua[63:32] * ub[63:32];
   end

   always_comb begin
      mid   = (p00_ff >> 32) + {32'd0, p01_ff[31:0]} + {32'd0, p10_ff[31:0]};
      lo_in = {mid[31:0], p00_ff[31:0]};
      hi_in = p11_ff + (p01_ff >> 32) + (p10_ff >> 32) + (mid >> 32);
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      neg2_ff <= neg1_ff;
   end

   always_comb begin
      if (hi_ff[63:22] != '0) begin
         mag = Q_LIM;
      end else begin
         mag = (lo_ff >> 24) | (hi_ff << 40);
         if (mag > Q_LIM) mag = Q_LIM;
      end
      r_in = neg2_ff ? $signed(64'd0 - mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

   assign r = r_ff;
endmodule

// File: rtl/tphc_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module tphc_div
   import tphc_pkg::*;
#(
   parameter int SIDE_W = 2
) (
   input  logic              clock,
   input  logic [DIV_W-1:0]  in_dividend,
   input  logic [DIV_W-1:0]  in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic [DIV_W-1:0]  out_quotient,
   output logic [SIDE_W-1:0] out_side
);
   logic [DIV_W-1:0]  rem_ff  [DIV_W];
   logic [DIV_W-1:0]  work_ff [DIV_W];
   logic [DIV_W-1:0]  dsr_ff  [DIV_W];
   logic [SIDE_W-1:0] side_ff [DIV_W];

   for (genvar i = 0; i < DIV_W; i++) begin : g_step
      logic [DIV_W-1:0]  rem_prev, work_prev, dsr_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DIV_W:0]    trial, diff;
      logic              ge;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign work_prev = in_dividend;
         assign dsr_prev  = in_divisor;
         assign side_prev = in_side;
      end else begin : g_rest
         assign rem_prev  = rem_ff[i-1];
         assign work_prev = work_ff[i-1];
         assign dsr_prev  = dsr_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      always_comb begin
         trial = {rem_prev, work_prev[DIV_W-1]};
         diff  = trial - {1'b0, dsr_prev};
         ge    = !diff[DIV_W];
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         work_ff[i] <= {work_prev[DIV_W-2:0], ge};
         dsr_ff[i]  <= dsr_prev;
         side_ff[i] <= side_prev;
      end
   end

   assign out_quotient = work_ff[DIV_W-1];
   assign out_side     = side_ff[DIV_W-1];
endmodule

// File: rtl/temp_pressure_humidity_compensation.sv
// top level: temperature, pressure and humidity compensation pipeline
//
//   channel   ports                      direction  beat taken when
//   request   start, busy, req_*         in         start high, busy low
//   response  rsp_valid, rsp_*           out        rsp_valid high (one cycle)
//   config    csr_we, csr_index, csr_wdata in         csr_we high
//
// one beat enters every cycle; busy is always low
// each beat comes out after passing the whole pipeline; the 32-step pressure
// divider sets most of its depth
// synchronous reset clears the valid chain; payload registers are not reset
// the receiver cannot stall, so nothing in the pipeline ever holds
module temp_pressure_humidity_compensation
   import tphc_pkg::*;
#(
   parameter int HUM_FRAC_BITS = HUM_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [19:0] req_raw_pressure,
   input  logic [19:0] req_raw_temperature,
   input  logic [15:0] req_raw_humidity,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_pa,
   output logic [16:0] rsp_humidity_frac,
   output logic signed [31:0] rsp_fine_temperature,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   localparam int LAT = 42;
   localparam int HUM_SH = 24 - HUM_FRAC_BITS;

   // ---------------- configuration registers
   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_lo_ff, press_hi_ff, hum_coeffs_ff;
   logic [15:0] press_nine_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_lo_ff    <= '0;
         press_hi_ff    <= '0;
         press_nine_ff  <= '0;
         hum_coeffs_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TEMP:       temp_coeffs_ff <= csr_wdata[47:0];
            CSR_PRESS_LO:   press_lo_ff    <= csr_wdata;
            CSR_PRESS_HI:   press_hi_ff    <= csr_wdata;
            CSR_PRESS_NINE: press_nine_ff  <= csr_wdata[15:0];
            CSR_HUM:        hum_coeffs_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // coefficient unpacking
   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [63:0] h1x32, h2x256;
   logic [7:0]  h3;
   logic signed [11:0] h4s, h5s;
   logic signed [7:0]  h6s;

   always_comb begin
      t1 = {16'd0, temp_coeffs_ff[15:0]};
      t2 = sx16(temp_coeffs_ff[31:16]);
      t3 = sx16(temp_coeffs_ff[47:32]);
      p1 = {16'd0, press_lo_ff[15:0]};
      p2 = sx16(press_lo_ff[31:16]);
      p3 = sx16(press_lo_ff[47:32]);
      p4 = sx16(press_lo_ff[63:48]);
      p5 = sx16(press_hi_ff[15:0]);
      p6 = sx16(press_hi_ff[31:16]);
      p7 = sx16(press_hi_ff[47:32]);
      p8 = sx16(press_hi_ff[63:48]);
      p9 = sx16(press_nine_ff);
      h1x32  = $signed({51'd0, hum_coeffs_ff[7:0], 5'd0});
      h2x256 = $signed({{40{hum_coeffs_ff[23]}}, hum_coeffs_ff[23:8], 8'd0});
      h3  = hum_coeffs_ff[31:24];
      h4s = hum_coeffs_ff[43:32];
      h5s = hum_coeffs_ff[55:44];
      h6s = hum_coeffs_ff[63:56];
   end

   // ---------------- valid chain
   logic [LAT:1] vld_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-1:1], start && !busy};
      end
   end

   assign rsp_valid = vld_ff[LAT];

   // ---------------- stage 1: temperature products
   logic [31:0] a1_in, dd_in, d_t;
   logic [31:0] st1_a_ff, st1_dd_ff;
   logic [15:0] st1_rh_ff;

   always_comb begin
      a1_in = sra32(({15'd0, req_raw_temperature[19:3]} - (t1 << 1)) * t2, 11);
      d_t   = {16'd0, req_raw_temperature[19:4]} - t1;
      dd_in = d_t * d_t;
   end

   always_ff @(posedge clock) begin
      st1_a_ff  <= a1_in;
      st1_dd_ff <= dd_in;
      st1_rh_ff <= req_raw_humidity;
   end

   // ---------------- stage 2: fine temperature
   logic [31:0] tf_in, tb_in, st2_tf_ff;
   logic [15:0] st2_rh_ff;

   always_comb begin
      tb_in = sra32(sra32(st1_dd_ff, 12) * t3, 14);
      tf_in = st1_a_ff + tb_in;
   end

   always_ff @(posedge clock) begin
      st2_tf_ff <= tf_in;
      st2_rh_ff <= st1_rh_ff;
   end

   // ---------------- stage 3: temperature out, pressure and humidity setup
   logic [31:0] t_in, t_ff;
   logic [31:0] pa, pq, qq_in, ap5_in, p2a_in;
   logic [31:0] p1_qq_ff, p1_ap5_ff, p1_p2a_ff;

   always_comb begin
      t_in   = sra32(st2_tf_ff * 32'd5 + 32'd128, 8);
      pa     = sra32(st2_tf_ff, 1) - 32'd64000;
      pq     = sra32(pa, 2);
      qq_in  = pq * pq;
      ap5_in = pa * p5;
      p2a_in = p2 * pa;
   end

   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      p1_qq_ff  <= qq_in;
      p1_ap5_ff <= ap5_in;
      p1_p2a_ff <= p2a_in;
   end

   // humidity entry: v, x, i and c
   logic signed [33:0] hv;
   logic signed [45:0] h5v;
   logic signed [41:0] h3v, h6v;
   logic signed [63:0] hx_in, hi_in, hc_in, hxa;
   logic signed [63:0] hx_ff, hi_ff, hc_ff;

   always_comb begin
      hv    = $signed({st2_tf_ff[31], st2_tf_ff[31], st2_tf_ff}) - 34'sd76800;
      h5v   = h5s * hv;
      h3v   = $signed({1'b0, h3}) * hv;
      h6v   = h6s * hv;
      hxa   = ($signed({48'd0, st2_rh_ff}) - (64'(h4s) <<< 6)) <<< 24;
      hx_in = hxa - (64'(h5v) <<< 10);
      hi_in = Q_ONE + div4_tz(64'(h3v));
      hc_in = div4_tz(64'(h6v));
   end

   always_ff @(posedge clock) begin
      hx_ff <= hx_in;
      hi_ff <= hi_in;
      hc_ff <= hc_in;
   end

   // ---------------- stage 4: pressure b term
   logic [31:0] pb_raw, pb_in, p3q_in;
   logic [31:0] p2_b_ff, p2_p3q_ff, p2_p2a_ff;

   always_comb begin
      pb_raw = sra32(p1_qq_ff, 11) * p6 + (p1_ap5_ff << 1);
      pb_in  = sra32(pb_raw, 2) + (p4 << 16);
      p3q_in = p3 * sra32(p1_qq_ff, 13);
   end

   always_ff @(posedge clock) begin
      p2_b_ff   <= pb_in;
      p2_p3q_ff <= p3q_in;
      p2_p2a_ff <= p1_p2a_ff;
   end

   // ---------------- stage 5: divisor scale
   logic [31:0] ps_in, p3_s_ff, p3_b_ff;

   always_comb begin
      ps_in = 32'd32768 + sra32(sra32(p2_p3q_ff, 3) + sra32(p2_p2a_ff, 1), 18);
   end

   always_ff @(posedge clock) begin
      p3_s_ff <= ps_in;
      p3_b_ff <= p2_b_ff;
   end

   // ---------------- stage 6: divisor and dividend
   logic [19:0] rp5;
   logic [31:0] pd_in, pn_in, p4_d_ff, p4_pn_ff;

   tphc_delay #(.WIDTH(20), .DEPTH(5)) u_dly_rp (
      .clock (clock),
      .d     (req_raw_pressure),
      .q     (rp5)
   );

   always_comb begin
      pd_in = sra32(p3_s_ff * p1, 15);
      pn_in = ((32'd1048576 - {12'd0, rp5}) - sra32(p3_b_ff, 12)) * 32'd3125;
   end

   always_ff @(posedge clock) begin
      p4_d_ff  <= pd_in;
      p4_pn_ff <= pn_in;
   end

   // ---------------- stages 7 to 38: divider
   // large dividends are divided first and doubled after, small ones doubled first
   logic [31:0] div_dividend, div_q;
   logic [1:0]  div_side_in, div_side;

   assign div_dividend = p4_pn_ff[31] ? p4_pn_ff : (p4_pn_ff << 1);
   assign div_side_in  = {p4_pn_ff[31], p4_d_ff == 32'd0};

   tphc_div #(.SIDE_W(2)) u_div (
      .clock        (clock),
      .in_dividend  (div_dividend),
      .in_divisor   (p4_d_ff),
      .in_side      (div_side_in),
      .out_quotient (div_q),
      .out_side     (div_side)
   );

   // ---------------- stage 39: quotient fix-up
   logic [31:0] post_p_ff;
   logic        post_dz_ff;

   always_ff @(posedge clock) begin
      post_p_ff  <= div_side[0] ? 32'd0 : (div_side[1] ? (div_q << 1) : div_q);
      post_dz_ff <= div_side[0];
   end

   // ---------------- stage 40: correction products
   logic [31:0] p8s, pp_in, pq8_in;
   logic [31:0] q1_p_ff, q1_pp_ff, q1_pq8_ff;
   logic        q1_dz_ff;

   always_comb begin
      p8s    = post_p_ff >> 3;
      pp_in  = p8s * p8s;
      pq8_in = (post_p_ff >> 2) * p8;
   end

   always_ff @(posedge clock) begin
      q1_p_ff   <= post_p_ff;
      q1_pp_ff  <= pp_in;
      q1_pq8_ff <= pq8_in;
      q1_dz_ff  <= post_dz_ff;
   end

   // ---------------- stage 41: correction sum
   logic [31:0] csum_in, q2_p_ff, q2_sum_ff;
   logic        q2_dz_ff;

   always_comb begin
      csum_in = sra32(p9 * (q1_pp_ff >> 13), 12) + sra32(q1_pq8_ff, 13) + p7;
   end

   always_ff @(posedge clock) begin
      q2_p_ff   <= q1_p_ff;
      q2_sum_ff <= csum_in;
      q2_dz_ff  <= q1_dz_ff;
   end

   // ---------------- stage 42: pressure out
   logic [31:0] press_ff;

   always_ff @(posedge clock) begin
      press_ff <= q2_dz_ff ? 32'd0 : (q2_p_ff + sra32(q2_sum_ff, 4));
   end

   assign rsp_pressure_pa = press_ff;

   // ---------------- humidity chain, stages 4 to 21
   logic signed [63:0] ci, m_ff, hy, hx10, hh, hh17, hg, w_ff, hf;
   logic signed [63:0] hcl;
   logic [63:0]        hsh;
   logic [16:0]        hum_ff;

   tphc_qmul u_qm_ci (.clock(clock), .a(hc_ff), .b(hi_ff), .r(ci));

   always_ff @(posedge clock) begin
      m_ff <= qsat(Q_ONE + ci);
   end

   tphc_qmul u_qm_y (.clock(clock), .a(h2x256), .b(m_ff), .r(hy));

   tphc_delay #(.WIDTH(64), .DEPTH(7)) u_dly_hx (
      .clock (clock),
      .d     (hx_ff),
      .q     (hx10)
   );

   tphc_qmul u_qm_h (.clock(clock), .a(hx10), .b(hy), .r(hh));

   tphc_qmul u_qm_g (.clock(clock), .a(h1x32), .b(hh), .r(hg));

   always_ff @(posedge clock) begin
      w_ff <= qsat(Q_ONE - hg);
   end

   tphc_delay #(.WIDTH(64), .DEPTH(4)) u_dly_hh (
      .clock (clock),
      .d     (hh),
      .q     (hh17)
   );

   tphc_qmul u_qm_f (.clock(clock), .a(hh17), .b(w_ff), .r(hf));

   // clamp to 0..100 %rh and drop to the output fraction
   always_comb begin
      hcl = hf;
      if (hf < 0) hcl = '0;
      if (hf > Q_HUNDRED) hcl = Q_HUNDRED;
      hsh = 64'(hcl) >> HUM_SH;
   end

   always_ff @(posedge clock) begin
      hum_ff <= hsh[16:0];
   end

   // ---------------- alignment to the output stage
   logic [31:0] t_out, tf_out;
   logic [16:0] hum_out;

   tphc_delay #(.WIDTH(32), .DEPTH(LAT - 3)) u_dly_t (
      .clock (clock), .d (t_ff), .q (t_out)
   );

   tphc_delay #(.WIDTH(32), .DEPTH(LAT - 2)) u_dly_tf (
      .clock (clock), .d (st2_tf_ff), .q (tf_out)
   );

   tphc_delay #(.WIDTH(17), .DEPTH(LAT - 21)) u_dly_hum (
      .clock (clock), .d (hum_ff), .q (hum_out)
   );

   assign rsp_temperature_centi = $signed(t_out);
   assign rsp_fine_temperature  = $signed(tf_out);
   assign rsp_humidity_frac     = hum_out;

   // ---------------- checks
   // every result beat stems from a request beat taken the pipeline depth earlier
   a_lat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result beat without matching request");

   // a zero divisor must carry through the divider to a zero pressure
   a_dz : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAT-4] && div_side[0]) |-> ##4 (rsp_pressure_pa == 32'd0))
      else $error("zero divisor not flagged through to pressure");

   if (HUM_FRAC_BITS <= 10) begin : g_hum_chk
      // humidity clamp survives the output shift
      a_hum : assert property (@(posedge clock) disable iff (reset)
         rsp_valid |-> (32'(rsp_humidity_frac) <= (32'd100 << HUM_FRAC_BITS)))
         else $error("humidity above full scale");
   end
endmodule

// File: bench/tphc_checker.sv
// checker: mirrors the calibration registers, predicts each sample record and compares
module tphc_checker
   import tphc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [19:0] req_raw_pressure,
   input  logic [19:0] req_raw_temperature,
   input  logic [15:0] req_raw_humidity,
   input  logic        rsp_valid,
   input  logic signed [31:0] rsp_temperature_centi,
   input  logic [31:0] rsp_pressure_pa,
   input  logic [16:0] rsp_humidity_frac,
   input  logic signed [31:0] rsp_fine_temperature,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = HUM_FRAC_BITS_DEF;
   localparam longint unsigned SAT_MAG = 64'd4611686018427387903;

   typedef struct {
      bit [31:0] temp_centi;
      bit [31:0] press_pa;
      bit [16:0] hum_frac;
      bit [31:0] t_fine;
   } comp_rec_type;

   bit [47:0] cal_temp;
   bit [63:0] cal_press_lo, cal_press_hi, cal_hum;
   bit [15:0] cal_p9;
   comp_rec_type awaited[$];
   int        n_bad;

   function automatic bit [31:0] shr_s(bit [31:0] x, int n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic bit [31:0] ext16(bit [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function automatic longint clip62(longint v);
      if (v > longint'(SAT_MAG)) return longint'(SAT_MAG);
      if (v < -longint'(SAT_MAG)) return -longint'(SAT_MAG);
      return v;
   endfunction

   // exact q24 product, truncated toward zero, saturated
   function automatic longint q24_mul(longint a, longint b);
      bit [63:0]  ma, mb;
      bit [127:0] prod, mag;
      bit         neg;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? 64'd0 - 64'(a) : 64'(a);
      mb = b < 0 ? 64'd0 - 64'(b) : 64'(b);
      prod = {64'd0, ma} * {64'd0, mb};
      mag = prod >> 24;
      if (mag > {64'd0, SAT_MAG}) mag = {64'd0, SAT_MAG};
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   function automatic bit [31:0] comp_pressure(bit [31:0] tf, bit [19:0] raw);
      bit [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, q, p, d;
      p1 = {16'd0, cal_press_lo[15:0]};
      p2 = ext16(cal_press_lo[31:16]);
      p3 = ext16(cal_press_lo[47:32]);
      p4 = ext16(cal_press_lo[63:48]);
      p5 = ext16(cal_press_hi[15:0]);
      p6 = ext16(cal_press_hi[31:16]);
      p7 = ext16(cal_press_hi[47:32]);
      p8 = ext16(cal_press_hi[63:48]);
      p9 = ext16(cal_p9);
      a = shr_s(tf, 1) - 32'd64000;
      q = shr_s(a, 2);
      b = shr_s(q * q, 11) * p6;
      b = b + ((a * p5) << 1);
      b = shr_s(b, 2) + (p4 << 16);
      a = shr_s(shr_s(p3 * shr_s(q * q, 13), 3) + shr_s(p2 * a, 1), 18);
      d = shr_s((32'd32768 + a) * p1, 15);
      if (d == 0) return 32'd0;   // zero divisor gives 0 Pa
      p = ((32'd1048576 - {12'd0, raw}) - shr_s(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / d;
      else p = (p / d) * 32'd2;
      a = shr_s(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = shr_s((p >> 2) * p8, 13);
      return p + shr_s(a + b + p7, 4);
   endfunction

   function automatic bit [16:0] comp_humidity(bit [31:0] tf, bit [15:0] raw);
      longint h1, h2, h3, h4, h5, h6, v, x, i, c, m, y, h;
      h1 = longint'(cal_hum[7:0]);
      h2 = $signed(cal_hum[23:8]);
      h3 = longint'(cal_hum[31:24]);
      h4 = $signed(cal_hum[43:32]);
      h5 = $signed(cal_hum[55:44]);
      h6 = $signed(cal_hum[63:56]);
      v = longint'($signed(tf)) - 76800;
      x = clip62((longint'(raw) - 64 * h4) * 16777216 - h5 * v * 1024);
      i = 16777216 + (h3 * v) / 4;
      c = (h6 * v) / 4;
      m = clip62(16777216 + q24_mul(c, i));
      y = q24_mul(h2 * 256, m);
      h = q24_mul(x, y);
      h = q24_mul(h, clip62(16777216 - q24_mul(h1 * 32, h)));
      if (h < 0) h = 0;
      if (h > 100 * 64'sd16777216) h = 100 * 64'sd16777216;
      return 17'(h >>> (24 - FRAC_BITS));
   endfunction

   function automatic comp_rec_type compensate(bit [19:0] rp, bit [19:0] rt,
                                               bit [15:0] rh);
      comp_rec_type r;
      bit [31:0] t1, t2, t3, a, b, d, tf;
      t1 = {16'd0, cal_temp[15:0]};
      t2 = ext16(cal_temp[31:16]);
      t3 = ext16(cal_temp[47:32]);
      a = shr_s((({12'd0, rt} >> 3) - (t1 << 1)) * t2, 11);
      d = ({12'd0, rt} >> 4) - t1;
      b = shr_s(shr_s(d * d, 12) * t3, 14);
      tf = a + b;
      r.temp_centi = shr_s(tf * 32'd5 + 32'd128, 8);
      r.press_pa = comp_pressure(tf, rp);
      r.hum_frac = comp_humidity(tf, rh);
      r.t_fine = tf;
      return r;
   endfunction

   assign fail_count = n_bad;
   assign pending = awaited.size();

   always @(posedge clock) begin
      comp_rec_type want;
      if (reset) begin
         cal_temp <= '0;
         cal_press_lo <= '0;
         cal_press_hi <= '0;
         cal_p9 <= '0;
         cal_hum <= '0;
         awaited.delete();
         n_bad <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TEMP:       cal_temp <= csr_wdata[47:0];
               CSR_PRESS_LO:   cal_press_lo <= csr_wdata;
               CSR_PRESS_HI:   cal_press_hi <= csr_wdata;
               CSR_PRESS_NINE: cal_p9 <= csr_wdata[15:0];
               CSR_HUM:        cal_hum <= csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy)
            awaited.push_back(compensate(req_raw_pressure, req_raw_temperature,
                                         req_raw_humidity));
         if (rsp_valid) begin
            if (awaited.size() == 0) begin
               if (n_bad < 10) $display("unexpected result beat at %0t", $realtime);
               n_bad <= n_bad + 1;
            end else begin
               want = awaited.pop_front();
               if (want.temp_centi !== rsp_temperature_centi
                   || want.press_pa !== rsp_pressure_pa
                   || want.hum_frac !== rsp_humidity_frac
                   || want.t_fine !== rsp_fine_temperature) begin
                  if (n_bad < 10)
                     $display({"mismatch at %0t: exp T=%0d P=%0d H=%0d F=%0d",
                               " got T=%0d P=%0d H=%0d F=%0d"},
                              $realtime, $signed(want.temp_centi), want.press_pa,
                              want.hum_frac, $signed(want.t_fine), rsp_temperature_centi,
                              rsp_pressure_pa, rsp_humidity_frac, rsp_fine_temperature);
                  n_bad <= n_bad + 1;
               end
            end
         end
      end
   end
endmodule

// File: bench/tb_temp_pressure_humidity_compensation.sv
// testbench top: drives sample records and calibration writes, gives the verdict
module tb_temp_pressure_humidity_compensation
   import tphc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // depth of the block plus margin, used when draining
   localparam int SETTLE = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [19:0] req_raw_pressure = '0;
   logic [19:0] req_raw_temperature = '0;
   logic [15:0] req_raw_humidity = '0;
   logic        rsp_valid;
   logic signed [31:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_pa;
   logic [16:0] rsp_humidity_frac;
   logic signed [31:0] rsp_fine_temperature;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;
   int          fail_count, pending;

   always #4 clock = ~clock;

   temp_pressure_humidity_compensation uut (.*);

   tphc_checker chk (.*);

   // one calibration write, launched on the falling edge
   task automatic write_cal(logic [2:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // one sample beat; start stays high if the next beat follows at once
   task automatic send_record(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
      @(negedge clock);
      start = 1'b1;
      req_raw_pressure = rp;
      req_raw_temperature = rt;
      req_raw_humidity = rh;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(int n);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // mostly back to back, some short gaps, a few long ones
   task automatic random_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) hold_off(0);
      else if (r < 90) hold_off($urandom_range(3, 1));
      else hold_off($urandom_range(40, 8));
   endtask

   // drain everything in flight, then let the pipe settle before touching the registers
   task automatic drain();
      hold_off(1);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_cal(logic [47:0] t, logic [63:0] plo, logic [63:0] phi,
                           logic [15:0] p9, logic [63:0] hum);
      write_cal(CSR_TEMP, {16'd0, t});
      write_cal(CSR_PRESS_LO, plo);
      write_cal(CSR_PRESS_HI, phi);
      write_cal(CSR_PRESS_NINE, {48'd0, p9});
      write_cal(CSR_HUM, hum);
   endtask

   // a typical factory calibration set
   localparam logic [47:0] TYP_T = {16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] TYP_PLO = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
   localparam logic [63:0] TYP_PHI = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [15:0] TYP_P9 = 16'd6000;
   localparam logic [63:0] TYP_HUM = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

   task automatic random_records(int n);
      repeat (n) begin
         if ($urandom_range(1)) begin
            // realistic readings around room conditions
            send_record(20'($urandom_range(480000, 300000)),
                        20'($urandom_range(600000, 450000)),
                        16'($urandom_range(45000, 15000)));
         end else begin
            send_record(20'($urandom), 20'($urandom), 16'($urandom));
         end
         random_gap();
      end
   endtask

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // registers at reset value: everything zero
      send_record('0, '0, '0);
      send_record('1, '1, '1);
      drain();

      // typical calibration, directed corners of the raw fields
      load_cal(TYP_T, TYP_PLO, TYP_PHI, TYP_P9, TYP_HUM);
      send_record(20'd415148, 20'd519888, 16'd30000);
      send_record('0, '0, '0);
      send_record('1, '1, '1);
      send_record(20'h80000, 20'h80000, 16'h8000);
      send_record(20'd1, 20'hFFFFF, 16'd0);
      send_record(20'hFFFFF, 20'd0, 16'hFFFF);
      // very dry and very wet readings to hit both humidity clamps
      send_record(20'd415148, 20'd519888, 16'd0);
      send_record(20'd415148, 20'd519888, 16'd65535);
      drain();

      // zero divisor: P1 = 0 forces pressure to 0
      load_cal(TYP_T, {TYP_PLO[63:16], 16'd0}, TYP_PHI, TYP_P9, TYP_HUM);
      send_record(20'd415148, 20'd519888, 16'd30000);
      send_record('1, '1, '1);
      random_records(150);
      drain();

      // all-ones registers: extreme coefficients, wrapping and saturation
      load_cal('1, '1, '1, '1, '1);
      send_record('0, '0, '0);
      send_record('1, '1, '1);
      random_records(200);
      drain();

      // sign-bit coefficients
      load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
               {4{16'h8000}}, 16'h8000, {8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF});
      send_record('1, 20'd0, '1);
      send_record(20'd0, '1, 16'd0);
      random_records(150);
      drain();

      // typical set, long random run
      load_cal(TYP_T, TYP_PLO, TYP_PHI, TYP_P9, TYP_HUM);
      random_records(600);
      drain();

      // random calibration sets
      repeat (4) begin
         load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom), {$urandom, $urandom});
         random_records(175);
         drain();
      end

      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
